@@ rtl/core/ovpc_pkg.sv @@
// Shared types and constants for the object-identifier view prefix check.
package ovpc_pkg;

    // Operation codes carried in the op field of an input transfer.
    localparam logic [1:0] OP_HDR   = 2'd0;
    localparam logic [1:0] OP_SUBID = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // Field widths fixed by the interface.
    localparam int IDX_W  = 4;
    localparam int VIEW_W = 8;
    localparam int LEN_W  = 5;
    localparam int POS_W  = 4;
    localparam int SUB_W  = 32;

    // Wide enough for a name position up to 255.
    localparam int QPOS_W = 8;

    typedef struct packed {
        logic [1:0]        op;
        logic [IDX_W-1:0]  entry_index;
        logic [VIEW_W-1:0] view_id;
        logic [LEN_W-1:0]  prefix_len;
        logic              included;
        logic              entry_valid;
        logic [POS_W-1:0]  position;
        logic [SUB_W-1:0]  subid;
        logic              last;
    } t_in;

    typedef struct packed {
        logic             allowed;
        logic             any_match;
        logic [IDX_W-1:0] best_entry;
        logic [LEN_W-1:0] best_len;
    } t_out;

    // Table write broadcast to every cell; range checks are already applied.
    typedef struct packed {
        logic              hdr_we;
        logic              sub_we;
        logic [IDX_W-1:0]  idx;
        logic [VIEW_W-1:0] view;
        logic [LEN_W-1:0]  len;
        logic              incl;
        logic              in_use;
        logic [POS_W-1:0]  pos;
        logic [SUB_W-1:0]  subid;
    } t_load;

    // Query token that walks down the cell chain, collecting the best match.
    typedef struct packed {
        logic              valid;
        logic              last;
        logic              cmp_en;
        logic [QPOS_W-1:0] cmp_pos;
        logic [QPOS_W-1:0] qpos;
        logic [VIEW_W-1:0] view;
        logic [SUB_W-1:0]  subid;
        logic              found;
        logic [IDX_W-1:0]  best_idx;
        logic [LEN_W-1:0]  best_len;
        logic              allowed;
    } t_tok;

endpackage

@@ rtl/core/oid_view_prefix_check_core.sv @@
// Top level of the object-identifier view prefix check: control, load decode and cell chain.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in_data  (t_in)
//  out     | output    | o_out_valid / i_out_ready  | o_out_data (t_out)
//
// A load transfer (entry header or prefix sub-id) is written straight into
// the addressed cell. A query transfer holds off all further input until its
// token leaves the chain: the token visits one cell per cycle, and each cell
// spends that cycle on a registered read of its prefix memory and one 32-bit
// compare. Reset (synchronous, active low) clears all entry headers and the position
// counter and sets the match bits; prefix memories hold unknown data until loaded.
// The finished result sits in an output register, so loads and non-final
// query sub-ids keep flowing while it waits; only a final query sub-id is
// held off until the previous result has been taken.
module oid_view_prefix_check_core #(
    parameter int ENTRIES    = 16,
    parameter int MAX_SUBIDS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ovpc_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output ovpc_pkg::t_out o_out_data
);
    import ovpc_pkg::*;

    localparam int QP_W = $clog2(MAX_SUBIDS + 1);

    logic              r_busy;
    logic [QP_W-1:0]   r_qpos;
    logic [VIEW_W-1:0] r_qview;
    t_tok              r_inj;
    logic              r_out_valid;
    t_out              r_out;

    logic              w_acc;
    logic              w_is_load;
    logic              w_is_query;
    logic              w_cmp_en;
    logic [QP_W-1:0]   n_qpos;
    t_load             w_load;
    t_tok              w_link [ENTRIES+1];
    t_tok              w_tail;

    // A final query sub-id would need the output slot, so hold it while a result waits.
    assign o_in_ready = !r_busy &&
                        !(r_out_valid && (i_in_data.op == OP_QUERY) && i_in_data.last);
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_is_load  = w_acc && ((i_in_data.op == OP_HDR) || (i_in_data.op == OP_SUBID));
    assign w_is_query = w_acc && (i_in_data.op == OP_QUERY);

    // Loads are ignored while a query is open or when they address past the table.
    always_comb begin
        logic [LEN_W-1:0] len_c;
        logic             ok;
        len_c = i_in_data.prefix_len;
        if (int'(i_in_data.prefix_len) > MAX_SUBIDS) begin
            len_c = LEN_W'(MAX_SUBIDS);
        end
        ok            = w_is_load && (r_qpos == '0) && (int'(i_in_data.entry_index) < ENTRIES);
        w_load.hdr_we = ok && (i_in_data.op == OP_HDR);
        w_load.sub_we = ok && (i_in_data.op == OP_SUBID) &&
                        (int'(i_in_data.position) < MAX_SUBIDS);
        w_load.idx    = i_in_data.entry_index;
        w_load.view   = i_in_data.view_id;
        w_load.len    = len_c;
        w_load.incl   = i_in_data.included;
        w_load.in_use = i_in_data.entry_valid;
        w_load.pos    = i_in_data.position;
        w_load.subid  = i_in_data.subid;
    end

    // The name position counter saturates at the deepest prefix.
    assign w_cmp_en = (int'(r_qpos) < MAX_SUBIDS);
    assign n_qpos   = w_cmp_en ? (r_qpos + QP_W'(1)) : r_qpos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_qpos      <= '0;
            r_qview     <= '0;
            r_inj       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_inj.valid <= w_is_query;
            if (w_is_query) begin
                r_busy         <= 1'b1;
                r_inj.last     <= i_in_data.last;
                r_inj.cmp_en   <= w_cmp_en;
                r_inj.cmp_pos  <= QPOS_W'(r_qpos);
                r_inj.qpos     <= QPOS_W'(n_qpos);
                r_inj.view     <= (r_qpos == '0) ? i_in_data.view_id : r_qview;
                r_inj.subid    <= i_in_data.subid;
                r_inj.found    <= 1'b0;
                r_inj.best_idx <= '0;
                r_inj.best_len <= '0;
                r_inj.allowed  <= 1'b0;
                if (r_qpos == '0) begin
                    r_qview <= i_in_data.view_id;
                end
                r_qpos <= i_in_data.last ? '0 : n_qpos;
            end
            if (w_tail.valid) begin
                r_busy <= 1'b0;
            end
            if (w_tail.valid && w_tail.last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tail.valid && w_tail.last) begin
            r_out.allowed    <= w_tail.found && w_tail.allowed;
            r_out.any_match  <= w_tail.found;
            r_out.best_entry <= w_tail.best_idx;
            r_out.best_len   <= w_tail.best_len;
        end
    end

    // Cell chain: the token enters at entry 0 and leaves after the last entry.
    assign w_link[0] = r_inj;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        ovpc_cell #(
            .CELL_IDX  (g),
            .MAX_SUBIDS(MAX_SUBIDS)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_load (w_load),
            .i_tok  (w_link[g]),
            .o_tok  (w_link[g+1])
        );
    end

    assign w_tail      = w_link[ENTRIES];
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    // A result only appears after a final query token has left the chain.
    a_result_from_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_tail.valid && w_tail.last))
        else $error("result raised without a finished query");

    // The output slot is free whenever a final token arrives.
    a_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tail.valid && w_tail.last) |-> !r_out_valid)
        else $error("result overwrote a pending result");

    // No transfer is taken while a token is in the chain.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !o_in_ready)
        else $error("input taken while chain busy");

    // The position counter never passes the deepest prefix.
    a_qpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_qpos) <= MAX_SUBIDS)
        else $error("name position counter out of range");

    // A query token is launched in the cycle after a query transfer.
    a_inject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_is_query |=> r_inj.valid && r_busy)
        else $error("query token not launched");
`endif

endmodule

@@ rtl/core/ovpc_cell.sv @@
// One view entry: header registers, prefix sub-id memory and match tracking.
module ovpc_cell #(
    parameter int CELL_IDX   = 0,
    parameter int MAX_SUBIDS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ovpc_pkg::t_load i_load,
    input  ovpc_pkg::t_tok  i_tok,
    output ovpc_pkg::t_tok  o_tok
);
    import ovpc_pkg::*;

    localparam int AW = (MAX_SUBIDS > 1) ? $clog2(MAX_SUBIDS) : 1;

    logic [SUB_W-1:0]  r_mem [MAX_SUBIDS];
    logic [SUB_W-1:0]  r_rd;
    logic [VIEW_W-1:0] r_view;
    logic [LEN_W-1:0]  r_len;
    logic              r_incl;
    logic              r_in_use;
    logic              r_match;
    t_tok              r_tok;

    logic              w_sel;
    logic              w_mismatch;
    logic              w_match_now;
    logic              w_cand;

    assign w_sel = (int'(i_load.idx) == CELL_IDX);

    // Prefix memory: written by loads, read every cycle at the incoming token's position.
    always_ff @(posedge i_clk) begin
        if (i_load.sub_we && w_sel) begin
            r_mem[AW'(i_load.pos)] <= i_load.subid;
        end
        r_rd <= r_mem[AW'(i_tok.cmp_pos)];
    end

    assign w_mismatch  = r_tok.valid && r_tok.cmp_en &&
                         (int'(r_tok.cmp_pos) < int'(r_len)) && (r_rd != r_tok.subid);
    assign w_match_now = r_match && !w_mismatch;
    assign w_cand      = r_tok.valid && r_tok.last && r_in_use && (r_view == r_tok.view) &&
                         w_match_now && (int'(r_len) <= int'(r_tok.qpos));

    // Lower cells are visited first, so a strict compare keeps the lower index on ties.
    always_comb begin
        o_tok = r_tok;
        if (w_cand && (!r_tok.found || (r_len > r_tok.best_len))) begin
            o_tok.found    = 1'b1;
            o_tok.best_idx = IDX_W'(CELL_IDX);
            o_tok.best_len = r_len;
            o_tok.allowed  = r_incl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view    <= '0;
            r_len     <= '0;
            r_incl    <= 1'b0;
            r_in_use  <= 1'b0;
            r_match   <= 1'b1;
            r_tok     <= '0;
        end else begin
            r_tok <= i_tok;
            if (i_load.hdr_we && w_sel) begin
                r_view   <= i_load.view;
                r_len    <= i_load.len;
                r_incl   <= i_load.incl;
                r_in_use <= i_load.in_use;
            end
            if (r_tok.valid) begin
                r_match <= r_tok.last ? 1'b1 : w_match_now;
            end
        end
    end

endmodule
